>>> src/isd_pkg.sv
// Shared constants, types and the dwell table for the ignition dwell scheduler.
package isd_pkg;

	localparam int CHANNELS = 4;
	localparam int PERIOD   = 30000000;

	localparam int FUNC_W  = 2;
	localparam int CYL_W   = 3;
	localparam int TIME_W  = 25;
	localparam int RPM_W   = 16;
	localparam int MV_W    = 16;
	localparam int DWELL_W = 13;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	// Register map: one word register at byte address 0
	localparam logic REG_DWELL_MAX = 1'b0;
	localparam logic [DWELL_W-1:0] DWELL_MAX_RST = 13'd5000;

	// Battery voltage thresholds in millivolts
	localparam logic [MV_W-1:0] MV_BAND_LOW  = 16'd11000;
	localparam logic [MV_W-1:0] MV_BAND_MID  = 16'd12500;
	localparam logic [MV_W-1:0] MV_BAND_HIGH = 16'd14000;

	// Engine speed thresholds in rpm
	localparam logic [RPM_W-1:0] RPM_FAST = 16'd8000;
	localparam logic [RPM_W-1:0] RPM_SLOW = 16'd1000;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_SCHED = 2'd0,
		FUNC_STOP  = 2'd1,
		FUNC_TICK  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		BAND_LOW  = 2'd0,
		BAND_MID  = 2'd1,
		BAND_HIGH = 2'd2,
		BAND_TOP  = 2'd3
	} band_t;

	typedef enum logic [1:0] {
		SPD_NOM  = 2'd0,
		SPD_FAST = 2'd1,
		SPD_SLOW = 2'd2
	} speed_t;

	// Per-channel update word from the top level
	typedef struct packed {
		logic              sched;
		logic              stop;
		logic              tick;
		logic [TIME_W-1:0] time_nxt;
		logic [TIME_W-1:0] dstart;
		logic [TIME_W-1:0] spark;
	} chan_ctl_t;

	// Base dwell scaled by 85/100 (fast) or 115/100 (slow), truncated
	function automatic logic [DWELL_W-1:0] dwell_lookup(band_t band, speed_t spd);
		logic [DWELL_W-1:0] d;
		d = 13'd3000;
		case (spd)
			SPD_FAST: begin
				case (band)
					BAND_LOW:  d = 13'd3825;
					BAND_MID:  d = 13'd2975;
					BAND_HIGH: d = 13'd2550;
					default:   d = 13'd2380;
				endcase
			end
			SPD_SLOW: begin
				case (band)
					BAND_LOW:  d = 13'd5175;
					BAND_MID:  d = 13'd4025;
					BAND_HIGH: d = 13'd3450;
					default:   d = 13'd3220;
				endcase
			end
			default: begin
				case (band)
					BAND_LOW:  d = 13'd4500;
					BAND_MID:  d = 13'd3500;
					BAND_HIGH: d = 13'd3000;
					default:   d = 13'd2800;
				endcase
			end
		endcase
		return d;
	endfunction

endpackage

>>> src/isd_apb_regs.sv
// APB configuration register holding the dwell clamp.
module isd_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [isd_pkg::APB_AW-1:0]  paddr,
	input  logic [isd_pkg::APB_DW-1:0]  pwdata,
	output logic [isd_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [isd_pkg::DWELL_W-1:0] dwell_max
);
	import isd_pkg::*;

	logic [DWELL_W-1:0] dwell_max_q;
	logic               sel_dwell;

	assign sel_dwell = (paddr[2] == REG_DWELL_MAX);
	assign pready    = 1'b1;
	assign dwell_max = dwell_max_q;

	// Write the clamp in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_max_q <= DWELL_MAX_RST;
		end else if (psel && penable && pwrite && sel_dwell) begin
			dwell_max_q <= pwdata[DWELL_W-1:0];
		end
	end

	// Return the register, zero elsewhere
	always_comb begin
		prdata = '0;
		if (sel_dwell) begin
			prdata = {{(APB_DW-DWELL_W){1'b0}}, dwell_max_q};
		end
	end

endmodule

>>> src/isd_dwell_calc.sv
// Dwell selection from battery voltage and engine speed, clamped to the maximum.
module isd_dwell_calc (
	input  logic [isd_pkg::MV_W-1:0]    battery_mv,
	input  logic [isd_pkg::RPM_W-1:0]   engine_rpm,
	input  logic [isd_pkg::DWELL_W-1:0] dwell_max,
	output logic [isd_pkg::DWELL_W-1:0] dwell
);
	import isd_pkg::*;

	band_t              band;
	speed_t             spd;
	logic [DWELL_W-1:0] raw;

	// Pick the voltage band
	always_comb begin
		if (battery_mv < MV_BAND_LOW) begin
			band = BAND_LOW;
		end else if (battery_mv < MV_BAND_MID) begin
			band = BAND_MID;
		end else if (battery_mv < MV_BAND_HIGH) begin
			band = BAND_HIGH;
		end else begin
			band = BAND_TOP;
		end
	end

	// Pick the speed correction
	always_comb begin
		if (engine_rpm > RPM_FAST) begin
			spd = SPD_FAST;
		end else if (engine_rpm < RPM_SLOW) begin
			spd = SPD_SLOW;
		end else begin
			spd = SPD_NOM;
		end
	end

	// Look up and clamp
	assign raw   = dwell_lookup(band, spd);
	assign dwell = (raw > dwell_max) ? dwell_max : raw;

endmodule

>>> src/isd_channel.sv
// One coil channel: compare registers, forced-low flag and coil drive.
module isd_channel (
	input  logic               clk,
	input  logic               arst_n,
	input  isd_pkg::chan_ctl_t ctl,
	output logic               coil
);
	import isd_pkg::*;

	logic [TIME_W-1:0] dstart_q;
	logic [TIME_W-1:0] spark_q;
	logic              forced_q;
	logic              coil_q;

	assign coil = coil_q;

	// Load compares on schedule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dstart_q <= '0;
			spark_q  <= '0;
		end else if (ctl.sched) begin
			dstart_q <= ctl.dstart;
			spark_q  <= ctl.spark;
		end
	end

	// Advance forced flag and coil level; spark low wins over dwell start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forced_q <= 1'b1;
			coil_q   <= 1'b0;
		end else if (ctl.sched) begin
			forced_q <= 1'b0;
		end else if (ctl.stop) begin
			forced_q <= 1'b1;
			coil_q   <= 1'b0;
		end else if (ctl.tick) begin
			if (forced_q || ctl.time_nxt == spark_q) begin
				coil_q <= 1'b0;
			end else if (ctl.time_nxt == dstart_q) begin
				coil_q <= 1'b1;
			end else if (ctl.time_nxt == '0) begin
				coil_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/ignition_dwell_scheduler_top.sv
// Top level of the four-channel ignition dwell scheduler.
// A new word is taken every cycle that in_ready is high:
// the counter, compare and coil registers update at the edge that accepts the
// word, and the result register shows the outcome from the next cycle on. A
// result waiting for out_ready holds in_ready low only while it stays untaken.
// A tick word advances the 1 us counter (wrapping at 30000000) and updates
// the coils; a schedule word loads one channel's dwell-start and spark
// compares; a stop word forces one coil low. coil_levels and timer_count
// always show the state after the last accepted word. The dwell clamp sits
// at APB byte address 0 and resets to 5000 us.
module ignition_dwell_scheduler_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [isd_pkg::APB_AW-1:0]  paddr,
	input  logic [isd_pkg::APB_DW-1:0]  pwdata,
	output logic [isd_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [isd_pkg::FUNC_W-1:0]  func,
	input  logic [isd_pkg::CYL_W-1:0]   cylinder,
	input  logic [isd_pkg::TIME_W-1:0]  target_time,
	input  logic [isd_pkg::RPM_W-1:0]   engine_rpm,
	input  logic [isd_pkg::MV_W-1:0]    battery_mv,
	input  logic [isd_pkg::TIME_W-1:0]  reference_count,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        accepted,
	output logic [isd_pkg::CHANNELS-1:0] coil_levels,
	output logic [isd_pkg::DWELL_W-1:0] dwell_applied,
	output logic [isd_pkg::TIME_W-1:0]  timer_count
);
	import isd_pkg::*;

	logic               take;
	logic               cyl_ok;
	logic               sched_ok;
	logic               stop_ok;
	logic               tick;
	logic [DWELL_W-1:0] dwell_max;
	logic [DWELL_W-1:0] dwell;
	logic [TIME_W-1:0]  dstart;
	logic [TIME_W:0]    time_sum;
	logic [TIME_W-1:0]  time_nxt;
	logic [TIME_W-1:0]  counter_q;
	logic               out_valid_q;
	logic               accepted_q;
	logic [DWELL_W-1:0] dwell_applied_q;

	isd_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.dwell_max (dwell_max)
	);

	isd_dwell_calc u_calc (
		.battery_mv (battery_mv),
		.engine_rpm (engine_rpm),
		.dwell_max  (dwell_max),
		.dwell      (dwell)
	);

	// Decode the incoming word
	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;
	assign cyl_ok   = (cylinder != '0) && (cylinder <= CYL_W'(CHANNELS));
	assign sched_ok = take && (func == FUNC_SCHED) && cyl_ok &&
	                  (engine_rpm != '0) && (target_time > reference_count);
	assign stop_ok  = take && (func == FUNC_STOP) && cyl_ok;
	assign tick     = take && (func == FUNC_TICK);

	// Dwell start is target minus dwell, floored at zero
	assign dstart = (target_time > TIME_W'(dwell)) ? (target_time - TIME_W'(dwell)) : '0;

	// Next counter value with wrap
	assign time_sum = {1'b0, counter_q} + (TIME_W+1)'(1);
	assign time_nxt = (time_sum >= (TIME_W+1)'(PERIOD)) ? '0 : time_sum[TIME_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else if (tick) begin
			counter_q <= time_nxt;
		end
	end

	// Coil channels
	for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
		chan_ctl_t ctl;

		assign ctl.sched    = sched_ok && (cylinder == CYL_W'(i + 1));
		assign ctl.stop     = stop_ok && (cylinder == CYL_W'(i + 1));
		assign ctl.tick     = tick;
		assign ctl.time_nxt = time_nxt;
		assign ctl.dstart   = dstart;
		assign ctl.spark    = target_time;

		isd_channel u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.coil   (coil_levels[i])
		);
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			accepted_q      <= sched_ok || stop_ok || tick;
			dwell_applied_q <= sched_ok ? dwell : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign dwell_applied = dwell_applied_q;
	assign timer_count   = counter_q;

	// Counter only moves on a tick word
	a_counter_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick |=> $stable(counter_q))
		else $error("counter moved without a tick word");

	// Counter stays below the period
	a_counter_range: assert property (@(posedge clk) disable iff (!arst_n)
		counter_q < TIME_W'(PERIOD))
		else $error("counter out of range");

	// Stopped cylinder one reads low after the stop
	a_stop_low: assert property (@(posedge clk) disable iff (!arst_n)
		stop_ok && cylinder == CYL_W'(1) |=> !coil_levels[0])
		else $error("coil not low after stop");

	// A rejected word carries no dwell
	a_reject_dwell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !accepted_q |-> dwell_applied_q == '0)
		else $error("dwell reported on rejected word");

endmodule

>>> tb/sv/tb_top.sv
// Testbench for the ignition dwell scheduler: random and directed words checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
	import isd_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam logic [APB_AW-1:0] DWELL_MAX_ADDR = APB_AW'(4 * REG_DWELL_MAX);
	localparam logic [TIME_W-1:0] TIME_ALL_ONES = {TIME_W{1'b1}};
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int WORDS_PER_PHASE = 262;
	localparam int PHASES = 6;

	typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

	typedef struct packed {
		logic                ok;
		logic [CHANNELS-1:0] coils;
		logic [DWELL_W-1:0]  dwell;
		logic [TIME_W-1:0]   count;
	} coil_result_t;

	// Tracks counter, compares and coil levels; holds expected result words in order
	class dwell_predictor;
		logic [DWELL_W-1:0] dwell_max;
		logic [TIME_W-1:0]  counter;
		logic [TIME_W-1:0]  dstart_cmp [CHANNELS];
		logic [TIME_W-1:0]  spark_cmp [CHANNELS];
		bit                 coil [CHANNELS];
		bit                 forced [CHANNELS];
		coil_result_t       expected_results [$];
		int                 errors;

		function new();
			dwell_max = DWELL_MAX_RST;
			counter = '0;
			errors = 0;
			for (int i = 0; i < CHANNELS; i++) begin
				dstart_cmp[i] = '0;
				spark_cmp[i] = '0;
				coil[i] = 1'b0;
				forced[i] = 1'b1;
			end
		endfunction

		function void set_dwell_max(logic [DWELL_W-1:0] v);
			dwell_max = v;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void flag(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				errors++;
				if (errors <= 10)
					$display("%0t mismatch on %s: expected %0d, got %0d",
						$realtime, name, exp_v, act_v);
			end
		endfunction

		// Apply one accepted input word and queue the result it should produce
		function void note_word(logic [FUNC_W-1:0] f, logic [CYL_W-1:0] cyl,
				logic [TIME_W-1:0] target, logic [RPM_W-1:0] rpm,
				logic [MV_W-1:0] mv, logic [TIME_W-1:0] ref_cnt);
			coil_result_t r;
			int unsigned d;
			int unsigned next;
			int c;
			bit cyl_ok;
			r = '0;
			cyl_ok = (cyl >= 1) && (cyl <= CHANNELS);
			c = int'(cyl) - 1;
			case (f)
				FUNC_SCHED: begin
					if (cyl_ok && rpm != 0 && target > ref_cnt) begin
						// pick base dwell from the battery band, then scale by speed
						if (mv < MV_BAND_LOW)
							d = 4500;
						else if (mv < MV_BAND_MID)
							d = 3500;
						else if (mv < MV_BAND_HIGH)
							d = 3000;
						else
							d = 2800;
						if (rpm > RPM_FAST)
							d = (d * 85) / 100;
						else if (rpm < RPM_SLOW)
							d = (d * 115) / 100;
						if (d > dwell_max)
							d = dwell_max;
						dstart_cmp[c] = (target > d) ? TIME_W'(target - d) : '0;
						spark_cmp[c] = target;
						forced[c] = 1'b0;
						r.ok = 1'b1;
						r.dwell = DWELL_W'(d);
					end
				end
				FUNC_STOP: begin
					if (cyl_ok) begin
						forced[c] = 1'b1;
						coil[c] = 1'b0;
						r.ok = 1'b1;
					end
				end
				FUNC_TICK: begin
					// advance the counter, then wrap low, dwell high, spark low in that order
					next = counter + 1;
					if (next >= PERIOD)
						next = 0;
					counter = TIME_W'(next);
					for (int i = 0; i < CHANNELS; i++) begin
						if (forced[i]) begin
							coil[i] = 1'b0;
						end else begin
							if (counter == 0)
								coil[i] = 1'b0;
							if (counter == dstart_cmp[i])
								coil[i] = 1'b1;
							if (counter == spark_cmp[i])
								coil[i] = 1'b0;
						end
					end
					r.ok = 1'b1;
				end
				default: ;
			endcase
			for (int i = 0; i < CHANNELS; i++)
				r.coils[i] = coil[i];
			r.count = counter;
			expected_results.push_back(r);
		endfunction

		// Compare one result word with the oldest expectation
		function void check_word(coil_result_t act);
			coil_result_t exp_r;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t result word with no expectation pending", $realtime);
			end else begin
				exp_r = expected_results.pop_front();
				flag("accepted", exp_r.ok, act.ok);
				flag("coil_levels", exp_r.coils, act.coils);
				flag("dwell_applied", exp_r.dwell, act.dwell);
				flag("timer_count", exp_r.count, act.count);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [FUNC_W-1:0]   func = '0;
	logic [CYL_W-1:0]    cylinder = '0;
	logic [TIME_W-1:0]   target_time = '0;
	logic [RPM_W-1:0]    engine_rpm = '0;
	logic [MV_W-1:0]     battery_mv = '0;
	logic [TIME_W-1:0]   reference_count = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                accepted;
	logic [CHANNELS-1:0] coil_levels;
	logic [DWELL_W-1:0]  dwell_applied;
	logic [TIME_W-1:0]   timer_count;

	dwell_predictor tracker;
	int tick_total = 0;
	int burst_left = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int rx_span = 0;
	rx_mode_t rx_mode = RX_OPEN;

	ignition_dwell_scheduler_top u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.cylinder        (cylinder),
		.target_time     (target_time),
		.engine_rpm      (engine_rpm),
		.battery_mv      (battery_mv),
		.reference_count (reference_count),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.accepted        (accepted),
		.coil_levels     (coil_levels),
		.dwell_applied   (dwell_applied),
		.timer_count     (timer_count)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Observe both channels at the edge, before any update lands
	always @(posedge clk) begin
		if (arst_n && tracker != null) begin
			if (out_valid && out_ready)
				tracker.check_word({accepted, coil_levels, dwell_applied, timer_count});
			if (in_valid && in_ready)
				tracker.note_word(func, cylinder, target_time, engine_rpm, battery_mv,
					reference_count);
		end
	end

	// Receiver: shifting stall patterns, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_requests != hold_served) begin
			hold_served++;
			hold_left = LONG_HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			if (rx_span == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_span = $urandom_range(8, 80);
			end
			rx_span--;
			case (rx_mode)
				RX_OPEN:  out_ready <= 1'b1;
				RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY: out_ready <= ($urandom_range(0, 9) > 5);
				default:  out_ready <= ~out_ready;
			endcase
		end
	end

	task automatic apb_access(input bit wr, input logic [APB_AW-1:0] addr,
			input logic [APB_DW-1:0] wd, output logic [APB_DW-1:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wd;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write the dwell clamp with junk in the upper bits, then read it back
	task automatic set_dwell_max(input logic [DWELL_W-1:0] v);
		logic [APB_DW-1:0] wd;
		logic [APB_DW-1:0] rd;
		wd = $urandom();
		wd[DWELL_W-1:0] = v;
		apb_access(1'b1, DWELL_MAX_ADDR, wd, rd);
		tracker.set_dwell_max(v);
		apb_access(1'b0, DWELL_MAX_ADDR, '0, rd);
		tracker.flag("dwell_max readback", v, rd[DWELL_W-1:0]);
	endtask

	// Offer one word and hold it until the block takes it
	task automatic send_word(input logic [FUNC_W-1:0] f, input logic [CYL_W-1:0] cyl,
			input logic [TIME_W-1:0] tgt, input logic [RPM_W-1:0] rpm,
			input logic [MV_W-1:0] mv, input logic [TIME_W-1:0] rc);
		func <= f;
		cylinder <= cyl;
		target_time <= tgt;
		engine_rpm <= rpm;
		battery_mv <= mv;
		reference_count <= rc;
		in_valid <= 1'b1;
		if (f == FUNC_TICK)
			tick_total++;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic idle_cycles(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Drop valid and wait until every expected result word has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	// Bursts of random length with random gaps between them
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 12);
			idle_cycles($urandom_range(1, 8));
		end
	endtask

	function automatic logic [RPM_W-1:0] pick_rpm();
		case ($urandom_range(0, 11))
			0: return 16'd1;
			1: return RPM_SLOW - 1;
			2: return RPM_SLOW;
			3: return RPM_SLOW + 1;
			4: return RPM_FAST - 1;
			5: return RPM_FAST;
			6: return RPM_FAST + 1;
			7: return {RPM_W{1'b1}};
			default: return RPM_W'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic logic [MV_W-1:0] pick_mv();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return MV_BAND_LOW - 1;
			2: return MV_BAND_LOW;
			3: return MV_BAND_MID - 1;
			4: return MV_BAND_MID;
			5: return MV_BAND_HIGH - 1;
			6: return MV_BAND_HIGH;
			7: return {MV_W{1'b1}};
			default: return MV_W'($urandom());
		endcase
	endfunction

	// Mostly ticks and well-formed schedules near the counter, some stops and noise
	task automatic random_word();
		logic [FUNC_W-1:0] f;
		logic [CYL_W-1:0]  cyl;
		logic [TIME_W-1:0] tgt;
		logic [TIME_W-1:0] rc;
		logic [RPM_W-1:0]  rpm;
		logic [MV_W-1:0]   mv;
		int unsigned       r;
		r = $urandom_range(0, 99);
		f = FUNC_TICK;
		cyl = CYL_W'($urandom());
		tgt = TIME_W'($urandom());
		rc = TIME_W'($urandom());
		rpm = RPM_W'($urandom());
		mv = MV_W'($urandom());
		if (r < 45) begin
			f = FUNC_TICK;
		end else if (r < 75) begin
			f = FUNC_SCHED;
			cyl = CYL_W'($urandom_range(1, CHANNELS));
			rpm = pick_rpm();
			mv = pick_mv();
			if ($urandom_range(0, 3) != 0)
				tgt = TIME_W'(tick_total + $urandom_range(1, 120));
			else if (tgt == 0)
				tgt = 1;
			if (tgt > tick_total && $urandom_range(0, 1) == 1)
				rc = TIME_W'(tick_total);
			else
				rc = TIME_W'($urandom_range(0, tgt - 1));
		end else if (r < 83) begin
			f = FUNC_STOP;
			cyl = CYL_W'($urandom_range(1, CHANNELS));
		end else begin
			f = FUNC_W'($urandom_range(0, 3));
		end
		send_word(f, cyl, tgt, rpm, mv, rc);
	endtask

	initial begin
		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: forced coils, rejects, every dwell band and speed range, extremes
		send_word(FUNC_TICK, 3'd1, '0, 16'd3000, 16'd12000, '0);
		send_word(FUNC_UNUSED, 3'd1, 25'd500, 16'd3000, 16'd12000, '0);
		send_word(FUNC_SCHED, 3'd0, 25'd500, 16'd3000, 16'd12000, '0);
		send_word(FUNC_SCHED, 3'd7, 25'd500, 16'd3000, 16'd12000, '0);
		send_word(FUNC_SCHED, 3'd5, 25'd500, 16'd3000, 16'd12000, '0);
		send_word(FUNC_SCHED, 3'd1, 25'd500, 16'd0, 16'd12000, '0);
		send_word(FUNC_SCHED, 3'd2, 25'd100, 16'd3000, 16'd12000, 25'd100);
		send_word(FUNC_SCHED, 3'd3, '0, 16'd3000, 16'd12000, '0);
		send_word(FUNC_SCHED, 3'd4, TIME_ALL_ONES, 16'd3000, 16'd12000, TIME_ALL_ONES);
		send_word(FUNC_SCHED, 3'd1, 25'd3, RPM_SLOW - 1, 16'd0, '0);
		send_word(FUNC_SCHED, 3'd2, TIME_ALL_ONES, RPM_FAST + 1, MV_BAND_LOW - 1, '0);
		send_word(FUNC_SCHED, 3'd3, TIME_W'(PERIOD - 1), RPM_SLOW, MV_BAND_LOW,
			TIME_W'(PERIOD - 2));
		send_word(FUNC_SCHED, 3'd4, 25'd5000, RPM_FAST, MV_BAND_MID - 1, 25'd1);
		send_word(FUNC_SCHED, 3'd4, 25'd5000, RPM_FAST - 1, MV_BAND_MID, 25'd1);
		send_word(FUNC_SCHED, 3'd1, 25'd4, {RPM_W{1'b1}}, MV_BAND_HIGH - 1, '0);
		send_word(FUNC_SCHED, 3'd2, 25'd6, 16'd1, MV_BAND_HIGH, '0);
		send_word(FUNC_SCHED, 3'd3, 25'd2800, RPM_SLOW + 1, {MV_W{1'b1}}, '0);
		repeat (4) send_word(FUNC_TICK, 3'd0, '0, '0, '0, '0);
		send_word(FUNC_STOP, 3'd0, '0, '0, '0, '0);
		send_word(FUNC_STOP, 3'd2, TIME_ALL_ONES, {RPM_W{1'b1}}, {MV_W{1'b1}}, TIME_ALL_ONES);
		send_word(FUNC_STOP, 3'd6, '0, '0, '0, '0);
		send_word(FUNC_TICK, 3'd7, TIME_ALL_ONES, {RPM_W{1'b1}}, {MV_W{1'b1}}, TIME_ALL_ONES);

		// Random phases, each under its own dwell clamp
		for (int p = 0; p < PHASES; p++) begin
			drain();
			repeat (3) @(posedge clk);
			case (p)
				0: set_dwell_max({DWELL_W{1'b1}});
				1: set_dwell_max('0);
				2: set_dwell_max(13'd12);
				3: set_dwell_max(13'd40);
				4: set_dwell_max(DWELL_W'($urandom_range(1, 200)));
				default: set_dwell_max(DWELL_W'($urandom_range(0, 8191)));
			endcase
			burst_left = 0;
			for (int k = 0; k < WORDS_PER_PHASE; k++) begin
				if (p == 2 && k == 100)
					hold_requests++;
				if (p == 3 && k == 130)
					drain();
				pace();
				random_word();
			end
		end

		drain();
		repeat (5) @(posedge clk);
		if (tracker.pending() != 0) begin
			tracker.errors += tracker.pending();
			$display("%0d expected result words never arrived", tracker.pending());
		end
		if (tracker.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> ignition_dwell_scheduler_top.f
src/isd_pkg.sv
src/isd_apb_regs.sv
src/isd_dwell_calc.sv
src/isd_channel.sv
src/ignition_dwell_scheduler_top.sv
tb/sv/tb_top.sv
